// ===== rtl/metrk_pkg.sv =====
// Shared types and constants of the motor encoder feedback tracker.
// No dependencies; every module of the block imports this package.

package metrk_pkg;

	localparam int MOTOR_COUNT = 4;
	localparam int AVG_DEPTH   = 6;

	localparam int SEL_W  = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
	localparam int AVG_LOG = $clog2(AVG_DEPTH);
	localparam int SLOT_W = (AVG_DEPTH > 1) ? AVG_LOG : 1;

	localparam int ID_W       = 11;
	localparam int OFS_W      = 13;
	localparam int POS_W      = 16;
	localparam int D_W        = 18;
	localparam int TURN_W     = 16;
	localparam int TOTAL_W    = 32;
	localparam int ANGLE_W    = 28;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_ID = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFS_M0   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFS_M1   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFS_M2   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFS_M3   = 3'd4;

	localparam logic [ID_W-1:0] FIRST_ID_RESET = 11'd513;

	localparam int ENC_SPAN     = 8191;
	localparam int UNWRAP_LIMIT = 4096;
	localparam int DEG_PER_TURN = 360;

	// ring sum and the reciprocal used for the ring mean
	localparam int RSUM_W    = D_W + AVG_LOG + 1;
	localparam int AVG_SHIFT = RSUM_W - 1 + AVG_LOG;
	localparam int AVG_Q_W   = RSUM_W - AVG_LOG;
	localparam logic [RSUM_W-1:0] AVG_MUL =
		RSUM_W'(((64'd1 << AVG_SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH);

	// 256/36 reduces to 64/9; division by 9 by reciprocal, exact below 2**32
	localparam int ANG_PRE_SHL = 6;
	localparam int ANG_SHIFT   = 33;
	localparam int ANG_MUL_W   = 30;
	localparam int ANGLE_DIV   = 9;
	localparam logic [ANG_MUL_W-1:0] ANG_MUL =
		ANG_MUL_W'(((64'd1 << ANG_SHIFT) + ANGLE_DIV - 1) / ANGLE_DIV);

	typedef logic [3:0][OFS_W-1:0] offset_set_t;

	typedef struct packed {
		logic             hit;
		logic [SEL_W-1:0] sel;
		logic [POS_W-1:0] pos;
		logic [15:0]      speed;
		logic [15:0]      current;
	} qentry_t;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== rtl/metrk_in_if.sv =====
// Request channel carrying one received feedback frame.
// Depends on nothing; widths are those of the frame fields.

interface metrk_in_if;
	logic        valid;
	logic        ready;
	logic [10:0] frame_id;
	logic [7:0]  pos_high;
	logic [7:0]  pos_low;
	logic [7:0]  speed_high;
	logic [7:0]  speed_low;
	logic [7:0]  current_high;
	logic [7:0]  current_low;

	modport source (output valid, frame_id, pos_high, pos_low, speed_high, speed_low,
		current_high, current_low, input ready);
	modport sink (input valid, frame_id, pos_high, pos_low, speed_high, speed_low,
		current_high, current_low, output ready);
endinterface

// ===== rtl/metrk_out_if.sv =====
// Result channel carrying one tracking result per frame.
// Depends on nothing; widths are those of the result fields.

interface metrk_out_if;
	logic               valid;
	logic               ready;
	logic               hit;
	logic [1:0]         motor_sel;
	logic [15:0]        position;
	logic signed [15:0] rotor_speed;
	logic signed [15:0] drive_current;
	logic signed [17:0] step_delta;
	logic signed [15:0] turn_count;
	logic signed [31:0] total_count;
	logic signed [27:0] shaft_angle;
	logic signed [17:0] average_delta;

	modport source (output valid, hit, motor_sel, position, rotor_speed, drive_current,
		step_delta, turn_count, total_count, shaft_angle, average_delta, input ready);
	modport sink (input valid, hit, motor_sel, position, rotor_speed, drive_current,
		step_delta, turn_count, total_count, shaft_angle, average_delta, output ready);
endinterface

// ===== rtl/motor_encoder_feedback_tracker_unit.sv =====
// Top level of the motor encoder feedback tracker: configuration registers,
// front end, request queue and tracking pipeline. Depends on metrk_pkg and both channels.
//
//   channel   | dir | handshake            | carries
//   feedback  | in  | valid / ready        | frame identifier and six payload bytes
//   result    | out | valid / ready        | hit, motor, raw fields, turns, angle, mean
//   wr_*      | in  | wr_en, no wait       | register index and data
//
// One request per cycle sustained while the result is accepted. Requests pass through
// the queue, then six pipeline stages, the first of which takes the state update
// and the last of which is the result register.
// Per-motor state is read combinationally and written as stage 1 loads, so frames for
// the same motor follow each other without gaps. Reset clears all motor state at once.
// A stalled result holds the pipeline; the two-entry queue absorbs the front end.

module motor_encoder_feedback_tracker_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	metrk_in_if.sink                         feedback,
	metrk_out_if.source                      result,
	input  logic                             wr_en,
	input  logic [metrk_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [metrk_pkg::CFG_DATA_W-1:0] wr_data
);
	import metrk_pkg::*;

	logic [ID_W-1:0] first_id_q;
	offset_set_t     offsets_q;
	qentry_t         push_data, head;
	logic            push, pop, q_full, q_nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_id_q <= FIRST_ID_RESET;
			offsets_q  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_FIRST_ID: first_id_q   <= wr_data[ID_W-1:0];
				REG_OFS_M0:   offsets_q[0] <= wr_data[OFS_W-1:0];
				REG_OFS_M1:   offsets_q[1] <= wr_data[OFS_W-1:0];
				REG_OFS_M2:   offsets_q[2] <= wr_data[OFS_W-1:0];
				REG_OFS_M3:   offsets_q[3] <= wr_data[OFS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	metrk_front u_front (
		.feedback  (feedback),
		.first_id  (first_id_q),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	metrk_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.nonempty  (q_nonempty),
		.full      (q_full)
	);

	metrk_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_nonempty (q_nonempty),
		.offsets    (offsets_q),
		.pop        (pop),
		.result     (result)
	);
endmodule

// ===== rtl/metrk_front.sv =====
// Front end: accepts frames, matches the identifier to a motor, packs the bytes.
// Depends on metrk_pkg and metrk_in_if.

module metrk_front (
	metrk_in_if.sink                 feedback,
	input  logic [metrk_pkg::ID_W-1:0] first_id,
	input  logic                     q_full,
	output logic                     push,
	output metrk_pkg::qentry_t       push_data
);
	import metrk_pkg::*;

	logic [ID_W:0] diff;

	assign feedback.ready = !q_full;
	assign push           = feedback.valid && !q_full;

	always_comb begin
		diff = {1'b0, feedback.frame_id} - {1'b0, first_id};
		// below the base the difference borrows into the top bit
		push_data.hit     = !diff[ID_W] && (diff[ID_W-1:0] < ID_W'(MOTOR_COUNT));
		push_data.sel     = diff[SEL_W-1:0];
		push_data.pos     = {feedback.pos_high, feedback.pos_low};
		push_data.speed   = {feedback.speed_high, feedback.speed_low};
		push_data.current = {feedback.current_high, feedback.current_low};
	end
endmodule

// ===== rtl/metrk_queue.sv =====
// Short request queue between the front end and the tracking pipeline.
// Depends on metrk_pkg for the entry type and depth.

module metrk_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  metrk_pkg::qentry_t push_data,
	input  logic               pop,
	output metrk_pkg::qentry_t head,
	output logic               nonempty,
	output logic               full
);
	import metrk_pkg::*;

	qentry_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// ===== rtl/metrk_back.sv =====
// Back end: per-motor state update, then a six-stage arithmetic pipeline that
// ends in the result register. Depends on metrk_pkg and metrk_out_if.

module metrk_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  metrk_pkg::qentry_t     head,
	input  logic                   q_nonempty,
	input  metrk_pkg::offset_set_t offsets,
	output logic                   pop,
	metrk_out_if.source            result
);
	import metrk_pkg::*;

	localparam logic signed [D_W-1:0] LIM_P = D_W'(UNWRAP_LIMIT);
	localparam logic signed [D_W-1:0] LIM_N = -LIM_P;
	localparam logic signed [D_W-1:0] SPAN  = D_W'(ENC_SPAN);

	// per-motor state
	logic [POS_W-1:0]         last_pos_q [MOTOR_COUNT];
	logic signed [TURN_W-1:0] turns_q    [MOTOR_COUNT];
	logic [SLOT_W-1:0]        slot_q     [MOTOR_COUNT];
	logic signed [RSUM_W-1:0] rsum_q     [MOTOR_COUNT];
	logic signed [D_W-1:0]    ring_q     [MOTOR_COUNT][AVG_DEPTH];

	// stage 0, combinational from the queue head
	logic signed [D_W-1:0]    d_raw, d_nxt, d_old, x_nxt;
	logic signed [TURN_W-1:0] turn_cur, turn_nxt;
	logic [SLOT_W-1:0]        slot_cur, slot_nxt;
	logic signed [RSUM_W-1:0] rsum_nxt;
	logic [SEL_W+1:0]         sel_w;
	logic [OFS_W-1:0]         ofs;

	logic adv1, adv2, adv3, adv4, adv5, adv6;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	// stage registers
	logic                     hit_s1, hit_s2, hit_s3, hit_s4, hit_s5;
	logic [1:0]               sel_s1, sel_s2, sel_s3, sel_s4, sel_s5;
	logic [POS_W-1:0]         pos_s1, pos_s2, pos_s3, pos_s4, pos_s5;
	logic [15:0]              spd_s1, spd_s2, spd_s3, spd_s4, spd_s5;
	logic [15:0]              cur_s1, cur_s2, cur_s3, cur_s4, cur_s5;
	logic signed [D_W-1:0]    d_s1, d_s2, d_s3, d_s4, d_s5;
	logic signed [TURN_W-1:0] t_s1, t_s2, t_s3, t_s4, t_s5;
	logic signed [RSUM_W-1:0] rsum_s1;
	logic signed [D_W-1:0]    x_s1;
	logic [24:0]              xm360_s2;
	logic                     xs_s2, rs_s2, vs_s4, vs_s5;
	logic signed [24:0]       t360_s2, t360_s3;
	logic signed [TOTAL_W-1:0] total_s2, total_s3, total_s4, total_s5;
	logic [2*RSUM_W-2:0]      avg_prod_s2;
	logic signed [12:0]       a_s3;
	logic signed [D_W-1:0]    avg_s3, avg_s4, avg_s5;
	logic [24:0]              vm_s4;
	logic [60:0]              aprod_s5;

	// stage 6 is the result register
	logic                      hit_s6;
	logic [1:0]                sel_s6;
	logic [POS_W-1:0]          pos_s6;
	logic [15:0]               spd_s6, cur_s6;
	logic signed [D_W-1:0]     d_s6, avg_s6;
	logic signed [TURN_W-1:0]  t_s6;
	logic signed [TOTAL_W-1:0] total_s6;
	logic signed [ANGLE_W-1:0] shaft_s6;

	// combinational helpers of later stages
	logic [16:0]              xm;
	logic [RSUM_W-2:0]        rmag;
	logic [11:0]              q0, qa;
	logic [13:0]              rem;
	logic [AVG_Q_W-1:0]       amag;
	logic signed [25:0]       v_sum;
	logic [ANGLE_W-1:0]       qang;

	assign adv6 = !vld_s6 || result.ready;
	assign adv5 = !vld_s5 || adv6;
	assign adv4 = !vld_s4 || adv5;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;
	assign pop  = q_nonempty && adv1;

	always_comb begin
		turn_cur = turns_q[head.sel];
		d_raw    = $signed({2'b00, head.pos}) - $signed({2'b00, last_pos_q[head.sel]});
		d_nxt    = d_raw;
		turn_nxt = turn_cur;
		// unwrap across the encoder span
		if (d_raw < LIM_N) begin
			d_nxt    = d_raw + SPAN;
			turn_nxt = turn_cur + 1'b1;
		end else if (d_raw > LIM_P) begin
			d_nxt    = d_raw - SPAN;
			turn_nxt = turn_cur - 1'b1;
		end
		slot_cur = slot_q[head.sel];
		d_old    = ring_q[head.sel][slot_cur];
		rsum_nxt = rsum_q[head.sel] + $signed({{(RSUM_W-D_W){d_nxt[D_W-1]}}, d_nxt})
			- $signed({{(RSUM_W-D_W){d_old[D_W-1]}}, d_old});
		slot_nxt = (slot_cur == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot_cur + 1'b1;
		sel_w    = {2'b00, head.sel};
		ofs      = offsets[sel_w[1:0]];
		x_nxt    = $signed({2'b00, head.pos}) - $signed({{(D_W-OFS_W){1'b0}}, ofs});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < MOTOR_COUNT; m++) begin
				last_pos_q[m] <= '0;
				turns_q[m]    <= '0;
				slot_q[m]     <= '0;
				rsum_q[m]     <= '0;
				for (int k = 0; k < AVG_DEPTH; k++) begin
					ring_q[m][k] <= '0;
				end
			end
		end else if (pop && head.hit) begin
			last_pos_q[head.sel]         <= head.pos;
			turns_q[head.sel]            <= turn_nxt;
			slot_q[head.sel]             <= slot_nxt;
			rsum_q[head.sel]             <= rsum_nxt;
			ring_q[head.sel][slot_cur]   <= d_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= q_nonempty;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
			if (adv6) vld_s6 <= vld_s5;
		end
	end

	always_comb begin
		xm    = x_s1[D_W-1] ? 17'(-x_s1) : 17'(x_s1);
		rmag  = rsum_s1[RSUM_W-1] ? (RSUM_W-1)'(-rsum_s1) : (RSUM_W-1)'(rsum_s1);
		// 8191 is 2**13 - 1: quotient by shift, remainder stays below twice the span
		q0    = xm360_s2[24:13];
		rem   = {1'b0, xm360_s2[12:0]} + {2'b00, q0};
		qa    = q0 + 12'(rem >= 14'(ENC_SPAN));
		amag  = avg_prod_s2[AVG_SHIFT +: AVG_Q_W];
		v_sum = $signed({{13{a_s3[12]}}, a_s3}) + $signed({t360_s3[24], t360_s3});
		qang  = aprod_s5[ANG_SHIFT +: ANGLE_W];
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			hit_s1  <= head.hit;
			sel_s1  <= sel_w[1:0];
			pos_s1  <= head.pos;
			spd_s1  <= head.speed;
			cur_s1  <= head.current;
			d_s1    <= d_nxt;
			t_s1    <= turn_nxt;
			rsum_s1 <= rsum_nxt;
			x_s1    <= x_nxt;
		end
		if (adv2) begin
			hit_s2      <= hit_s1;
			sel_s2      <= sel_s1;
			pos_s2      <= pos_s1;
			spd_s2      <= spd_s1;
			cur_s2      <= cur_s1;
			d_s2        <= d_s1;
			t_s2        <= t_s1;
			xs_s2       <= x_s1[D_W-1];
			xm360_s2    <= {8'b0, xm} * 25'(DEG_PER_TURN);
			t360_s2     <= $signed({{9{t_s1[TURN_W-1]}}, t_s1}) * $signed(25'(DEG_PER_TURN));
			total_s2    <= $signed({{16{t_s1[TURN_W-1]}}, t_s1}) * $signed(32'(ENC_SPAN))
				+ $signed({16'b0, pos_s1});
			rs_s2       <= rsum_s1[RSUM_W-1];
			avg_prod_s2 <= {{RSUM_W{1'b0}}, rmag} * {{(RSUM_W-1){1'b0}}, AVG_MUL};
		end
		if (adv3) begin
			hit_s3   <= hit_s2;
			sel_s3   <= sel_s2;
			pos_s3   <= pos_s2;
			spd_s3   <= spd_s2;
			cur_s3   <= cur_s2;
			d_s3     <= d_s2;
			t_s3     <= t_s2;
			total_s3 <= total_s2;
			t360_s3  <= t360_s2;
			a_s3     <= xs_s2 ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
			avg_s3   <= rs_s2 ? D_W'(-$signed({1'b0, amag})) : D_W'($signed({1'b0, amag}));
		end
		if (adv4) begin
			hit_s4   <= hit_s3;
			sel_s4   <= sel_s3;
			pos_s4   <= pos_s3;
			spd_s4   <= spd_s3;
			cur_s4   <= cur_s3;
			d_s4     <= d_s3;
			t_s4     <= t_s3;
			total_s4 <= total_s3;
			avg_s4   <= avg_s3;
			vs_s4    <= v_sum[25];
			vm_s4    <= v_sum[25] ? 25'(-v_sum) : 25'(v_sum);
		end
		if (adv5) begin
			hit_s5   <= hit_s4;
			sel_s5   <= sel_s4;
			pos_s5   <= pos_s4;
			spd_s5   <= spd_s4;
			cur_s5   <= cur_s4;
			d_s5     <= d_s4;
			t_s5     <= t_s4;
			total_s5 <= total_s4;
			avg_s5   <= avg_s4;
			vs_s5    <= vs_s4;
			aprod_s5 <= {30'b0, vm_s4, {ANG_PRE_SHL{1'b0}}} * {31'b0, ANG_MUL};
		end
		if (adv6) begin
			// a frame for no motor reports zeros
			hit_s6   <= hit_s5;
			sel_s6   <= hit_s5 ? sel_s5 : '0;
			pos_s6   <= hit_s5 ? pos_s5 : '0;
			spd_s6   <= hit_s5 ? spd_s5 : '0;
			cur_s6   <= hit_s5 ? cur_s5 : '0;
			d_s6     <= hit_s5 ? d_s5 : '0;
			t_s6     <= hit_s5 ? t_s5 : '0;
			total_s6 <= hit_s5 ? total_s5 : '0;
			avg_s6   <= hit_s5 ? avg_s5 : '0;
			shaft_s6 <= !hit_s5 ? '0 : (vs_s5 ? -$signed(qang) : $signed(qang));
		end
	end

	assign result.valid         = vld_s6;
	assign result.hit           = hit_s6;
	assign result.motor_sel     = sel_s6;
	assign result.position      = pos_s6;
	assign result.rotor_speed   = $signed(spd_s6);
	assign result.drive_current = $signed(cur_s6);
	assign result.step_delta    = d_s6;
	assign result.turn_count    = t_s6;
	assign result.total_count   = total_s6;
	assign result.shaft_angle   = shaft_s6;
	assign result.average_delta = avg_s6;
endmodule
